>>> hw/rtl/http_response_status_parser_macros.svh
// assertion macros for the http response status parser checker
// used by hrsp_checker.sv; needs nothing else
`ifndef HTTP_RESPONSE_STATUS_PARSER_MACROS_SVH
`define HTTP_RESPONSE_STATUS_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HRSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrsp assertion failed");

// next-cycle implication, disabled while reset is low
`define HRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrsp assertion failed");

`endif

>>> hw/rtl/hrsp_pkg.sv
// types and constants of the http response status parser
// no dependencies
`default_nettype none

package hrsp_pkg;

    // one result item as it waits in the output queue
    typedef struct packed {
        logic              kind;
        logic signed [10:0] status_code;
        logic              has_body;
        logic [7:0]        body_byte;
        logic              end_of_run;
    } t_result;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BODY   = 1'b1;

    localparam logic signed [10:0] CODE_NONE      = -11'sd1;
    localparam logic signed [10:0] CODE_NO_STATUS = 11'sd502;
    localparam logic signed [10:0] CODE_MAX       = 11'sd1023;
    localparam logic signed [10:0] CODE_MIN       = -11'sd1024;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // output queue, room for the two results of one item plus slack
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // whitespace as atoi sees it
    function automatic logic f_is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/http_response_status_parser.sv
// Accepts one response byte per cycle and turns it into at most two result items,
// in the cycle after acceptance. Status line parsing, the header scan and body
// truncation are per-byte updates of a few registers; results go into a four-entry
// output queue. The first body byte of a packet yields the status item and the byte
// item together, so one extra item is queued once per packet; input is taken while
// the queue has room for two items, which keeps the rate at one item per cycle
// whenever the output side takes one item per cycle. The status code converter
// handles the kept characters combinationally. No clearing pass after reset.
// Depends on hrsp_pkg.
`default_nettype none

module http_response_status_parser #(
    parameter int MAX_BODY_BYTES = 100,
    parameter int CODE_CHARS     = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_byte_in,
    input  wire logic               i_last_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_kind,
    output logic signed [10:0]      o_status_code,
    output logic                    o_has_body,
    output logic [7:0]              o_body_byte,
    output logic                    o_end_of_run
);
    import hrsp_pkg::*;

    localparam int CW = $clog2(CODE_CHARS + 1);
    localparam int BW = $clog2(MAX_BODY_BYTES + 1);

    // converter scan steps
    localparam logic [1:0] CV_SKIP   = 2'd0;
    localparam logic [1:0] CV_DIGITS = 2'd1;
    localparam logic [1:0] CV_STOP   = 2'd2;

    typedef enum logic [3:0] {
        PH_STATUS   = 4'b0001,
        PH_HEADER   = 4'b0010,
        PH_BODY_NEW = 4'b0100,
        PH_BODY     = 4'b1000
    } t_phase;

    // atoi over the kept characters, saturated to 11 bits
    function automatic logic signed [10:0] f_convert(
        input logic [CODE_CHARS-1:0][7:0] chars
    );
        logic [1:0]         st;
        logic               neg;
        logic [14:0]        v;
        logic [7:0]         c;
        logic signed [15:0] s;
        st  = CV_SKIP;
        neg = 1'b0;
        v   = '0;
        for (int i = 0; i < CODE_CHARS; i++) begin
            c = chars[i];
            if (st == CV_SKIP) begin
                if (!f_is_ws(c)) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        neg = (c == CH_MINUS);
                        st  = CV_DIGITS;
                    end else if (f_is_digit(c)) begin
                        v  = 15'(c - CH_ZERO);
                        st = CV_DIGITS;
                    end else begin
                        st = CV_STOP;
                    end
                end
            end else if (st == CV_DIGITS) begin
                if (f_is_digit(c)) begin
                    v = 15'(v * 15'd10 + 15'(c - CH_ZERO));
                end else begin
                    st = CV_STOP;
                end
            end
        end
        s = neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
        if (s > 16'(CODE_MAX)) begin
            s = 16'(CODE_MAX);
        end else if (s < 16'(CODE_MIN)) begin
            s = 16'(CODE_MIN);
        end
        return 11'(s);
    endfunction

    t_phase                     r_phase, n_phase;
    logic                       r_in_window, n_in_window;
    logic [CODE_CHARS-1:0][7:0] r_code_chars, n_code_chars;
    logic [CW-1:0]              r_char_count, n_char_count;
    logic signed [10:0]         r_code_value, n_code_value;
    logic                       r_line_blank, n_line_blank;
    logic [BW-1:0]              r_body_count, n_body_count;
    logic                       r_held_valid, n_held_valid;
    logic [7:0]                 r_held_byte, n_held_byte;

    t_result                    r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]         r_wptr, r_rptr;
    logic [FIFO_CW-1:0]         r_count;

    logic                       in_accept;
    logic                       out_pop;
    logic [1:0]                 push_num;
    t_result                    res0, res1, status_res, body_res;

    assign in_accept   = i_in_valid && o_in_ready;
    assign out_pop     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_out_valid = (r_count != '0);

    // per-byte parser update and result selection
    always_comb begin
        n_phase      = r_phase;
        n_in_window  = r_in_window;
        n_code_chars = r_code_chars;
        n_char_count = r_char_count;
        n_code_value = r_code_value;
        n_line_blank = r_line_blank;
        n_body_count = r_body_count;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        push_num     = 2'd0;
        res0         = '0;
        res1         = '0;
        status_res   = '0;
        body_res     = '0;

        if (in_accept) begin
            unique case (r_phase)
                PH_STATUS: begin
                    if (i_byte_in == CH_LF) begin
                        if (r_code_value == CODE_NONE) begin
                            n_code_value = CODE_NO_STATUS;
                        end
                        n_phase      = PH_HEADER;
                        n_line_blank = 1'b1;
                    end else if (i_byte_in == CH_SPACE) begin
                        if (r_in_window) begin
                            n_code_value = f_convert(r_code_chars);
                        end
                        n_in_window = !r_in_window;
                    end else if (r_in_window && r_char_count < CW'(CODE_CHARS)) begin
                        for (int k = 0; k < CODE_CHARS; k++) begin
                            if (r_char_count == CW'(k)) begin
                                n_code_chars[k] = i_byte_in;
                            end
                        end
                        n_char_count = CW'(r_char_count + 1'b1);
                    end
                end
                PH_HEADER: begin
                    if (i_byte_in == CH_LF) begin
                        if (r_line_blank) begin
                            n_phase = PH_BODY_NEW;
                        end else begin
                            n_line_blank = 1'b1;
                        end
                    end else if (i_byte_in != CH_CR) begin
                        n_line_blank = 1'b0;
                    end
                end
                PH_BODY_NEW, PH_BODY: begin
                    n_phase = PH_BODY;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            status_res.kind        = KIND_STATUS;
            status_res.status_code = n_code_value;
            body_res.kind          = KIND_BODY;

            if (r_phase == PH_BODY_NEW || r_phase == PH_BODY) begin
                // body byte: pass, hold the final kept one, or drop
                if (r_body_count < BW'(MAX_BODY_BYTES)) begin
                    if (r_body_count == BW'(MAX_BODY_BYTES - 1) && !i_last_byte) begin
                        n_held_byte  = i_byte_in;
                        n_held_valid = 1'b1;
                    end else begin
                        body_res.body_byte  = i_byte_in;
                        body_res.end_of_run = i_last_byte;
                        push_num            = 2'd1;
                    end
                    n_body_count = BW'(r_body_count + 1'b1);
                end else if (i_last_byte && r_held_valid) begin
                    body_res.body_byte  = r_held_byte;
                    body_res.end_of_run = 1'b1;
                    push_num            = 2'd1;
                end
                if (r_phase == PH_BODY_NEW) begin
                    status_res.has_body = 1'b1;
                    res0     = status_res;
                    res1     = body_res;
                    push_num = 2'(push_num + 1'b1);
                end else begin
                    res0 = body_res;
                end
            end else if (i_last_byte) begin
                // packet ended before any body byte
                status_res.end_of_run = 1'b1;
                res0     = status_res;
                push_num = 2'd1;
            end

            // end of packet returns the parser state to its reset values
            if (i_last_byte) begin
                n_phase      = PH_STATUS;
                n_in_window  = 1'b0;
                n_code_chars = '0;
                n_char_count = '0;
                n_code_value = CODE_NONE;
                n_line_blank = 1'b0;
                n_body_count = '0;
                n_held_valid = 1'b0;
                n_held_byte  = '0;
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_STATUS;
            r_in_window  <= 1'b0;
            r_code_chars <= '0;
            r_char_count <= '0;
            r_code_value <= CODE_NONE;
            r_line_blank <= 1'b0;
            r_body_count <= '0;
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_in_window  <= n_in_window;
            r_code_chars <= n_code_chars;
            r_char_count <= n_char_count;
            r_code_value <= n_code_value;
            r_line_blank <= n_line_blank;
            r_body_count <= n_body_count;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
        end
    end

    // output queue storage
    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_fifo[r_wptr] <= res0;
        end
        if (push_num == 2'd2) begin
            r_fifo[FIFO_AW'(r_wptr + 1'b1)] <= res1;
        end
    end

    // output queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= FIFO_AW'(r_wptr + push_num);
            r_rptr  <= FIFO_AW'(r_rptr + out_pop);
            r_count <= FIFO_CW'(r_count + push_num - out_pop);
        end
    end

    // head of the queue drives the result ports
    assign o_kind        = r_fifo[r_rptr].kind;
    assign o_status_code = r_fifo[r_rptr].status_code;
    assign o_has_body    = r_fifo[r_rptr].has_body;
    assign o_body_byte   = r_fifo[r_rptr].body_byte;
    assign o_end_of_run  = r_fifo[r_rptr].end_of_run;

endmodule

`default_nettype wire

>>> hw/rtl/hrsp_checker.sv
// port-level checker for the http response status parser, bound to the top level
// depends on http_response_status_parser_macros.svh
`default_nettype none

`include "http_response_status_parser_macros.svh"

module hrsp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_kind,
    input wire logic signed [10:0] o_status_code,
    input wire logic               o_has_body,
    input wire logic [7:0]         o_body_byte,
    input wire logic               o_end_of_run
);

    // a waiting result item is not withdrawn
    `HRSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // body items carry no code and no body flag
    `HRSP_ASSERT_NOW(a_body_clean, i_clk, i_rst_n, o_out_valid && o_kind, o_status_code == 11'sd0 && !o_has_body)

    // status item announcing a body never ends the run
    `HRSP_ASSERT_NOW(a_status_body, i_clk, i_rst_n, o_out_valid && !o_kind && o_has_body, !o_end_of_run && o_body_byte == 8'd0)

    // status item without a body always ends the run
    `HRSP_ASSERT_NOW(a_status_last, i_clk, i_rst_n, o_out_valid && !o_kind && !o_has_body, o_end_of_run)

endmodule

bind http_response_status_parser hrsp_checker u_hrsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_status_code (o_status_code),
    .o_has_body    (o_has_body),
    .o_body_byte   (o_body_byte),
    .o_end_of_run  (o_end_of_run)
);

`default_nettype wire
